// ===== rtl/nsc_pkg.sv =====
// Shared types and constants for the nucleotide substitution counter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package nsc_pkg;

  // counters
  localparam int COUNT_BITS_DEF = 20;
  localparam int OUT_COUNT_BITS = 20;
  localparam int NUM_CELLS      = 16;
  localparam int READOUT_LEN    = NUM_CELLS + 1;

  // result kinds
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_SITES = 1'b1;

  // one aligned column
  typedef struct packed {
    logic [1:0] base_a;
    logic       gap_a;
    logic [1:0] base_b;
    logic       gap_b;
    logic [1:0] base_c;
    logic       gap_c;
    logic       last_site;
  } col_t;

  // update control toward the counter bank
  typedef struct packed {
    logic apply;      // column leaves the input register this cycle
    logic clear;      // last column: counters restart from zero
    logic three_way;  // ancestor inference mode
  } upd_t;

endpackage

`default_nettype wire

// ===== rtl/nsc_if.sv =====
// Channel interfaces of the substitution counter: columns, results, config.
// Depends on nsc_pkg for the result count width.
`default_nettype none

interface nsc_col_if;
  logic       valid;
  logic       ready;
  logic [1:0] base_a;
  logic       gap_a;
  logic [1:0] base_b;
  logic       gap_b;
  logic [1:0] base_c;
  logic       gap_c;
  logic       last_site;

  modport source (output valid, base_a, gap_a, base_b, gap_b, base_c, gap_c, last_site,
                  input ready);
  modport sink   (input valid, base_a, gap_a, base_b, gap_b, base_c, gap_c, last_site,
                  output ready);
endinterface

interface nsc_res_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [1:0]                         row;
  logic [1:0]                         col;
  logic [nsc_pkg::OUT_COUNT_BITS-1:0] count;
  logic                               last;

  modport source (output valid, kind, row, col, count, last, input ready);
  modport sink   (input valid, kind, row, col, count, last, output ready);
endinterface

interface nsc_cfg_if;
  logic valid;
  logic ready;
  logic three_way_mode;

  modport source (output valid, three_way_mode, input ready);
  modport sink   (input valid, three_way_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/nsc_count_bank.sv =====
// Counter bank: 4x4 saturating substitution counters plus the site counter.
// Depends on nsc_pkg (col_t, upd_t, NUM_CELLS).
`default_nettype none

module nsc_count_bank #(
  parameter int COUNT_BITS = nsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire nsc_pkg::upd_t                                     upd_i,
  input  wire nsc_pkg::col_t                                     col_i,
  output logic [nsc_pkg::NUM_CELLS-1:0][COUNT_BITS-1:0]          cell_upd_o,
  output logic [COUNT_BITS-1:0]                                  site_upd_o
);

  logic [nsc_pkg::NUM_CELLS-1:0][COUNT_BITS-1:0] cell_q, cell_d;
  logic [COUNT_BITS-1:0]                         site_q, site_d;

  logic       used;
  logic [1:0] anc;
  logic       ab_eq, ac_eq, bc_eq;

  // site selection and ancestor choice
  always_comb begin
    ab_eq = (col_i.base_a == col_i.base_b);
    ac_eq = (col_i.base_a == col_i.base_c);
    bc_eq = (col_i.base_b == col_i.base_c);
    if (upd_i.three_way) begin
      used = !col_i.gap_a && !col_i.gap_b && !col_i.gap_c && (ab_eq || ac_eq || bc_eq);
      anc  = (ab_eq || ac_eq) ? col_i.base_a : col_i.base_b;
    end else begin
      used = !col_i.gap_a && !col_i.gap_b;
      anc  = col_i.base_a;
    end
  end

  // saturating add of a small amount
  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] v,
                                                    input logic [1:0]            inc);
    logic [COUNT_BITS:0] s;
    s = {1'b0, v} + (COUNT_BITS+1)'(inc);
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  // per-cell increments: up to three in three-way mode
  always_comb begin
    for (int k = 0; k < nsc_pkg::NUM_CELLS; k++) begin
      logic [1:0] r, c;
      logic [1:0] inc;
      r = 2'(k >> 2);
      c = 2'(k);
      inc = 2'd0;
      if (used && anc == r) begin
        if (upd_i.three_way) begin
          inc = 2'((col_i.base_a == c)) + 2'((col_i.base_b == c)) + 2'((col_i.base_c == c));
        end else begin
          inc = 2'((col_i.base_b == c));
        end
      end
      cell_upd_o[k] = sat_add(cell_q[k], inc);
    end
    site_upd_o = sat_add(site_q, {1'b0, used});
  end

  // next state: count, or restart after the last column
  always_comb begin
    cell_d = cell_q;
    site_d = site_q;
    if (upd_i.apply) begin
      if (upd_i.clear) begin
        cell_d = '0;
        site_d = '0;
      end else begin
        cell_d = cell_upd_o;
        site_d = site_upd_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
      site_q <= '0;
    end else begin
      cell_q <= cell_d;
      site_q <= site_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nucleotide_substitution_counter.sv =====
// Top level of the nucleotide substitution counter.
// Depends on nsc_pkg, the channel interfaces in nsc_if and nsc_count_bank.
//
// One aligned column is taken per cycle unless a held last column blocks the
// input register; it is counted into the 4x4 saturating counters as it leaves
// that register. A column flagged last_site is counted, then its 16 cell
// counts (row-major) and the site count are copied into a 17-beat readout
// register and the counters restart at zero; the readout drains at one beat
// per cycle whenever results are taken, while new columns keep counting. A
// further last column waits in the input register only while the previous
// readout still has beats left; other columns wait only behind it.
// Counts wider than the 20-bit result field are reported clipped to its
// maximum. three_way_mode is to be written only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module nucleotide_substitution_counter #(
  parameter int COUNT_BITS = nsc_pkg::COUNT_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nsc_cfg_if.sink   cfg_i,
  nsc_col_if.sink   in_i,
  nsc_res_if.source out_o
);

  localparam int RdLen    = nsc_pkg::READOUT_LEN;
  localparam int RdIdxW   = $clog2(RdLen);
  localparam int OutW     = nsc_pkg::OUT_COUNT_BITS;
  localparam int ExtW     = (COUNT_BITS > OutW) ? COUNT_BITS : OutW;
  localparam logic [RdIdxW-1:0] RdLastIdx = RdIdxW'(RdLen - 1);

  // configuration register
  logic mode_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.three_way_mode;
    end
  end

  // input register
  logic          s1_valid_q;
  nsc_pkg::col_t s1_col_q;
  logic          s1_go;
  logic          rd_free;
  logic          in_acc;
  logic          out_acc;

  logic              rd_busy_q, rd_busy_d;
  logic [RdIdxW-1:0] rd_idx_q, rd_idx_d;
  logic [RdLen-1:0][OutW-1:0] rd_data_q, rd_data_d;

  assign out_acc     = out_o.valid && out_o.ready;
  assign rd_free     = !rd_busy_q || (out_acc && rd_idx_q == RdLastIdx);
  assign s1_go       = s1_valid_q && (!s1_col_q.last_site || rd_free);
  assign in_i.ready  = !s1_valid_q || s1_go;
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q <= '{base_a: in_i.base_a, gap_a: in_i.gap_a,
                    base_b: in_i.base_b, gap_b: in_i.gap_b,
                    base_c: in_i.base_c, gap_c: in_i.gap_c,
                    last_site: in_i.last_site};
    end
  end

  // counters
  nsc_pkg::upd_t                                  upd;
  logic [nsc_pkg::NUM_CELLS-1:0][COUNT_BITS-1:0]  cell_upd;
  logic [COUNT_BITS-1:0]                          site_upd;

  assign upd = '{apply: s1_go, clear: s1_col_q.last_site, three_way: mode_q};

  nsc_count_bank #(
    .COUNT_BITS (COUNT_BITS)
  ) u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .col_i      (s1_col_q),
    .cell_upd_o (cell_upd),
    .site_upd_o (site_upd)
  );

  // clip a counter to the result field
  function automatic logic [OutW-1:0] clip(input logic [COUNT_BITS-1:0] v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return (e > ExtW'({OutW{1'b1}})) ? {OutW{1'b1}} : e[OutW-1:0];
  endfunction

  // readout shift register
  always_comb begin
    rd_busy_d = rd_busy_q;
    rd_idx_d  = rd_idx_q;
    rd_data_d = rd_data_q;
    if (s1_go && s1_col_q.last_site) begin
      for (int k = 0; k < nsc_pkg::NUM_CELLS; k++) begin
        rd_data_d[k] = clip(cell_upd[k]);
      end
      rd_data_d[RdLen-1] = clip(site_upd);
      rd_idx_d  = '0;
      rd_busy_d = 1'b1;
    end else if (out_acc) begin
      for (int k = 0; k < RdLen - 1; k++) begin
        rd_data_d[k] = rd_data_q[k+1];
      end
      rd_idx_d = rd_idx_q + RdIdxW'(1);
      if (rd_idx_q == RdLastIdx) begin
        rd_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_busy_q <= rd_busy_d;
      rd_idx_q  <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= rd_data_d;
  end

  // result beat
  logic rd_on_sites;
  assign rd_on_sites = (rd_idx_q == RdLastIdx);
  assign out_o.valid = rd_busy_q;
  assign out_o.kind  = rd_on_sites ? nsc_pkg::KIND_SITES : nsc_pkg::KIND_CELL;
  assign out_o.row   = rd_on_sites ? 2'd0 : rd_idx_q[3:2];
  assign out_o.col   = rd_on_sites ? 2'd0 : rd_idx_q[1:0];
  assign out_o.count = rd_data_q[0];
  assign out_o.last  = rd_on_sites;

  // checks
  a_sites_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == nsc_pkg::KIND_SITES) |-> out_o.last)
    else $error("site count beat without last");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_col_q.last_site && !rd_free) |=> (s1_valid_q && s1_col_q.last_site))
    else $error("last column dropped while readout busy");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last && !s1_go) |=> !out_o.valid)
    else $error("readout continued past its final beat");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_busy_q |-> (rd_idx_q <= RdLastIdx))
    else $error("readout index out of range");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for nucleotide_substitution_counter: a column driver, a readout
// monitor and a substitution-count predictor, with random idling on both channels.
// Depends on rtl/nsc_pkg.sv, rtl/nsc_if.sv and the block's RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;

  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_BITS) - 64'd1;
  localparam longint unsigned FIELD_MAX = (64'd1 << OUT_COUNT_BITS) - 64'd1;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 4;

  localparam logic MODE_PAIR  = 1'b0;
  localparam logic MODE_THREE = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [1:0]                row;
    logic [1:0]                col;
    logic [OUT_COUNT_BITS-1:0] count;
    logic                      last;
  } readout_t;

  logic clk_i;
  logic rst_ni;

  nsc_cfg_if cfg_ch ();
  nsc_col_if col_ch ();
  nsc_res_if res_ch ();

  nucleotide_substitution_counter #(
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (col_ch),
    .out_o (res_ch)
  );

  // predictor state
  longint unsigned cell_cnt [NUM_CELLS];
  longint unsigned site_cnt;
  logic            mode_now;

  col_t     column_q [$];
  readout_t readout_q [$];

  int cols_queued;
  int cols_taken;
  int res_expected;
  int res_seen;
  int fail_cnt;
  int cycle_cnt;
  bit tx_gap_en;
  bit rx_stall_en;
  int gap_left;
  int stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(24, 5);
  endfunction

  function automatic longint unsigned sat_inc(longint unsigned v);
    return (v < CNT_MAX) ? v + 64'd1 : v;
  endfunction

  function automatic logic [OUT_COUNT_BITS-1:0] clip(longint unsigned v);
    return (v > FIELD_MAX) ? FIELD_MAX[OUT_COUNT_BITS-1:0] : v[OUT_COUNT_BITS-1:0];
  endfunction

  function automatic void bump_cell(logic [1:0] r, logic [1:0] c);
    cell_cnt[{r, c}] = sat_inc(cell_cnt[{r, c}]);
  endfunction

  // count one accepted column; on the last column queue the 17-beat readout and clear
  function automatic void count_column(col_t c);
    logic [1:0] anc;
    bit         used;
    readout_t   r;
    used = 1'b0;
    anc  = c.base_a;
    if (mode_now == MODE_PAIR) begin
      if (!c.gap_a && !c.gap_b) begin
        bump_cell(c.base_a, c.base_b);
        site_cnt = sat_inc(site_cnt);
      end
    end else if (!c.gap_a && !c.gap_b && !c.gap_c) begin
      // majority ancestor: first symbol wins any agreement it is part of, else second/third pair
      if (c.base_a == c.base_b || c.base_a == c.base_c) begin
        used = 1'b1;
      end else if (c.base_b == c.base_c) begin
        anc  = c.base_b;
        used = 1'b1;
      end
      if (used) begin
        bump_cell(anc, c.base_a);
        bump_cell(anc, c.base_b);
        bump_cell(anc, c.base_c);
        site_cnt = sat_inc(site_cnt);
      end
    end
    if (c.last_site) begin
      for (int k = 0; k < NUM_CELLS; k++) begin
        r.kind  = KIND_CELL;
        r.row   = k[3:2];
        r.col   = k[1:0];
        r.count = clip(cell_cnt[k]);
        r.last  = 1'b0;
        readout_q.push_back(r);
        cell_cnt[k] = 0;
      end
      r.kind  = KIND_SITES;
      r.row   = 2'd0;
      r.col   = 2'd0;
      r.count = clip(site_cnt);
      r.last  = 1'b1;
      readout_q.push_back(r);
      site_cnt = 0;
      res_expected += READOUT_LEN;
    end
  endfunction

  // column driver
  always @(posedge clk_i) begin
    col_t taken;
    col_t nxt;
    if (rst_ni) begin
      if (col_ch.valid && col_ch.ready) begin
        taken.base_a    = col_ch.base_a;
        taken.gap_a     = col_ch.gap_a;
        taken.base_b    = col_ch.base_b;
        taken.gap_b     = col_ch.gap_b;
        taken.base_c    = col_ch.base_c;
        taken.gap_c     = col_ch.gap_c;
        taken.last_site = col_ch.last_site;
        count_column(taken);
        cols_taken++;
      end
      // hold a beat that was not taken, otherwise idle or present the next column
      if (!(col_ch.valid && !col_ch.ready)) begin
        if (gap_left > 0) begin
          col_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (column_q.size() > 0) begin
          nxt = column_q.pop_front();
          col_ch.base_a    <= nxt.base_a;
          col_ch.gap_a     <= nxt.gap_a;
          col_ch.base_b    <= nxt.base_b;
          col_ch.gap_b     <= nxt.gap_b;
          col_ch.base_c    <= nxt.base_c;
          col_ch.gap_c     <= nxt.gap_c;
          col_ch.last_site <= nxt.last_site;
          col_ch.valid     <= 1'b1;
          gap_left <= tx_gap_en ? pick_gap() : 0;
        end else begin
          col_ch.valid <= 1'b0;
        end
      end
    end
  end

  // readout monitor and checker
  always @(posedge clk_i) begin
    readout_t got;
    readout_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind  = res_ch.kind;
        got.row   = res_ch.row;
        got.col   = res_ch.col;
        got.count = res_ch.count;
        got.last  = res_ch.last;
        if (readout_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected beat: kind %0d row %0d col %0d count %0d last %0d",
                     got.kind, got.row, got.col, got.count, got.last);
        end else begin
          want = readout_q.pop_front();
          res_seen++;
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch at beat %0d: expected kind %0d row %0d col %0d count %0d last %0d",
                       res_seen, want.kind, want.row, want.col, want.count, want.last);
              $display("  got kind %0d row %0d col %0d count %0d last %0d",
                       got.kind, got.row, got.col, got.count, got.last);
            end
          end
        end
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rx_stall_en && $urandom_range(99) < 25) begin
        res_ch.ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic col_t column(logic [1:0] a, logic ga, logic [1:0] b, logic gb,
                                  logic [1:0] c, logic gc, logic last);
    col_t v;
    v.base_a    = a;
    v.gap_a     = ga;
    v.base_b    = b;
    v.gap_b     = gb;
    v.base_c    = c;
    v.gap_c     = gc;
    v.last_site = last;
    return v;
  endfunction

  // keep the pending queue short
  task automatic send_column(col_t c);
    wait (cols_queued - cols_taken < 32);
    column_q.push_back(c);
    cols_queued++;
  endtask

  // wait until the block is idle: every column taken, every readout beat seen
  task automatic settle();
    wait (cols_taken == cols_queued && res_seen == res_expected);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk_i);
    cfg_ch.three_way_mode <= m;
    cfg_ch.valid <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (cfg_ch.ready) break;
    end
    cfg_ch.valid <= 1'b0;
    mode_now = m;
  endtask

  // random column, mostly well formed for the current mode
  function automatic col_t random_column(logic m, int last_pct);
    col_t v;
    int   r;
    logic [31:0] raw;
    logic [1:0] x;
    logic [1:0] y;
    raw = $urandom();
    v = raw[$bits(col_t)-1:0];
    v.gap_a = 1'b0;
    v.gap_b = 1'b0;
    v.gap_c = 1'b0;
    r = $urandom_range(99);
    if (m == MODE_THREE) begin
      x = 2'($urandom_range(3));
      y = x ^ 2'($urandom_range(3, 1));
      if (r < 75) begin
        case ($urandom_range(3))
          0: begin v.base_a = x; v.base_b = x; v.base_c = x; end
          1: begin v.base_a = x; v.base_b = x; v.base_c = y; end
          2: begin v.base_a = x; v.base_b = y; v.base_c = x; end
          default: begin v.base_a = y; v.base_b = x; v.base_c = x; end
        endcase
      end else if (r < 88) begin
        // all three differ
        v.base_a = x;
        v.base_b = y;
        do v.base_c = 2'($urandom_range(3)); while (v.base_c == x || v.base_c == y);
      end else begin
        v.gap_a = 1'($urandom_range(1));
        v.gap_b = 1'($urandom_range(1));
        v.gap_c = 1'($urandom_range(1));
      end
    end else if (r >= 80) begin
      v.gap_a = 1'($urandom_range(1));
      v.gap_b = 1'($urandom_range(1));
      v.gap_c = 1'($urandom_range(1));
    end
    v.last_site = ($urandom_range(99) < last_pct);
    return v;
  endfunction

  // stimulus
  initial begin
    logic phase_mode [6];
    int   last_pct;
    phase_mode = '{MODE_PAIR, MODE_THREE, MODE_THREE, MODE_PAIR, MODE_THREE, MODE_PAIR};
    rst_ni = 1'b0;
    col_ch.valid = 1'b0;
    col_ch.base_a = 2'd0;
    col_ch.gap_a = 1'b0;
    col_ch.base_b = 2'd0;
    col_ch.gap_b = 1'b0;
    col_ch.base_c = 2'd0;
    col_ch.gap_c = 1'b0;
    col_ch.last_site = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.three_way_mode = 1'b0;
    for (int k = 0; k < NUM_CELLS; k++) cell_cnt[k] = 0;
    site_cnt = 0;
    mode_now = MODE_PAIR;
    cols_queued = 0;
    cols_taken = 0;
    res_expected = 0;
    res_seen = 0;
    fail_cnt = 0;
    cycle_cnt = 0;
    gap_left = 0;
    stall_left = 0;
    tx_gap_en = 1'b1;
    rx_stall_en = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pair mode: corners, ignored third symbol, gaps, back-to-back last columns
    write_mode(MODE_PAIR);
    send_column(column(2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0, 1'b0));
    send_column(column(2'd3, 1'b0, 2'd3, 1'b0, 2'd3, 1'b1, 1'b0));
    send_column(column(2'd0, 1'b0, 2'd3, 1'b0, 2'd1, 1'b0, 1'b0));
    send_column(column(2'd3, 1'b0, 2'd0, 1'b0, 2'd2, 1'b0, 1'b0));
    send_column(column(2'd1, 1'b0, 2'd2, 1'b0, 2'd3, 1'b1, 1'b0));
    send_column(column(2'd2, 1'b1, 2'd1, 1'b0, 2'd0, 1'b0, 1'b0));
    send_column(column(2'd2, 1'b0, 2'd1, 1'b1, 2'd0, 1'b0, 1'b0));
    send_column(column(2'd3, 1'b1, 2'd3, 1'b1, 2'd3, 1'b1, 1'b0));
    send_column(column(2'd2, 1'b0, 2'd1, 1'b0, 2'd0, 1'b0, 1'b1));
    send_column(column(2'd1, 1'b1, 2'd1, 1'b0, 2'd1, 1'b0, 1'b1));
    settle();

    // three-way mode: each majority shape, no majority, each gap
    write_mode(MODE_THREE);
    send_column(column(2'd3, 1'b0, 2'd3, 1'b0, 2'd3, 1'b0, 1'b0));
    send_column(column(2'd0, 1'b0, 2'd0, 1'b0, 2'd3, 1'b0, 1'b0));
    send_column(column(2'd1, 1'b0, 2'd2, 1'b0, 2'd1, 1'b0, 1'b0));
    send_column(column(2'd0, 1'b0, 2'd3, 1'b0, 2'd3, 1'b0, 1'b0));
    send_column(column(2'd0, 1'b0, 2'd1, 1'b0, 2'd2, 1'b0, 1'b0));
    send_column(column(2'd2, 1'b1, 2'd2, 1'b0, 2'd2, 1'b0, 1'b0));
    send_column(column(2'd2, 1'b0, 2'd2, 1'b1, 2'd2, 1'b0, 1'b0));
    send_column(column(2'd2, 1'b0, 2'd2, 1'b0, 2'd2, 1'b1, 1'b0));
    send_column(column(2'd0, 1'b0, 2'd0, 1'b0, 2'd0, 1'b0, 1'b1));
    settle();

    // random phases; counts carry across a mode change until the next last column
    for (int p = 0; p < 6; p++) begin
      write_mode(phase_mode[p]);
      tx_gap_en = (p != 0) && (p != 3);
      rx_stall_en = (p != 0);
      last_pct = (p == 4) ? 30 : ((p % 2 == 0) ? 8 : 15);
      for (int n = 0; n < 50; n++) send_column(random_column(phase_mode[p], last_pct));
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && readout_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d beats still expected", fail_cnt, readout_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
